// File: rtl/bct_pkg.sv
// ----------------------------------------------------------------------------
// bct_pkg
// Shared types and constants for the BLDC commutation timing block.
// ----------------------------------------------------------------------------
package bct_pkg;

  localparam int unsigned DATA_W              = 16;
  localparam int unsigned MIN_ADVANCE_DIVISOR = 4;
  localparam int unsigned IN_TDATA_W          = 24;
  localparam int unsigned IN_TUSER_W          = 2;
  localparam int unsigned OUT_TDATA_W         = 72;
  localparam int unsigned CFG_INDEX_W         = 2;

  localparam logic [DATA_W-1:0] STEP_TIMEOUT_RESET = 16'd65535;
  localparam logic [DATA_W-1:0] DRAG_STEP_RESET    = 16'd4000;
  localparam logic [DATA_W-1:0] START_PERIOD_RESET = 16'd4000;
  localparam logic [DATA_W-1:0] COUNT_MAX          = 16'hFFFF;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_STEP_TIMEOUT_RELOAD = 2'd0,
    REG_DRAG_STEP_RELOAD    = 2'd1,
    REG_START_STEP_PERIOD   = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    KIND_ZERO_CROSS = 2'd0,
    KIND_TIMEOUT    = 2'd1,
    KIND_COMMUTATE  = 2'd2
  } event_kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_DRAG   = 2'd1,
    MODE_CLOSED = 2'd2
  } run_mode_t;

  typedef struct packed {
    logic [DATA_W-1:0] step_timeout_reload;
    logic [DATA_W-1:0] drag_step_reload;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [1:0]        run_mode;
    logic [DATA_W-1:0] timer_count;
  } event_t;

  typedef struct packed {
    logic [DATA_W-1:0] failed_steps;
    logic [DATA_W-1:0] good_steps;
    logic [DATA_W-1:0] step_estimate;
    logic [DATA_W-1:0] reload_value;
    logic              reload_valid;
    logic              zero_cross_off;
    logic              commutate;
  } result_t;

endpackage

// File: rtl/bct_cfg_regs.sv
// ----------------------------------------------------------------------------
// bct_cfg_regs
// Configuration registers written through the plain write port.
// ----------------------------------------------------------------------------
module bct_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [bct_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bct_pkg::DATA_W-1:0] cfg_data,
  output bct_pkg::cfg_t              cfg
);
  import bct_pkg::*;

  // start step period only matters at reset, where it is back at its reset value
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_timeout_reload <= STEP_TIMEOUT_RESET;
      cfg.drag_step_reload    <= DRAG_STEP_RESET;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_STEP_TIMEOUT_RELOAD: cfg.step_timeout_reload <= cfg_data;
        REG_DRAG_STEP_RELOAD:    cfg.drag_step_reload    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/bct_step_unit.sv
// ----------------------------------------------------------------------------
// bct_step_unit
// Period filter and step counters; computes the result of one event.
// ----------------------------------------------------------------------------
module bct_step_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            update,
  input  bct_pkg::event_t ev,
  input  bct_pkg::cfg_t   cfg,
  output bct_pkg::result_t res
);
  import bct_pkg::*;

  logic [DATA_W-1:0] step_period;
  logic [DATA_W-1:0] good_count;
  logic [DATA_W-1:0] fail_count;
  logic [DATA_W-1:0] step_period_next;
  logic [DATA_W-1:0] good_count_next;
  logic [DATA_W-1:0] fail_count_next;

  logic              running;
  logic              early;
  logic [DATA_W+5:0] avg32_sum;
  logic [DATA_W+6:0] avg64_sum;
  logic [DATA_W-1:0] avg32;
  logic [DATA_W-1:0] avg64;
  logic [DATA_W-1:0] good_inc;
  logic [DATA_W-1:0] fail_inc;

  always_comb begin
    running  = (run_mode_t'(ev.run_mode) == MODE_DRAG) ||
               (run_mode_t'(ev.run_mode) == MODE_CLOSED);
    early    = ev.timer_count < (step_period / MIN_ADVANCE_DIVISOR);
    // p*31 + c = p*32 - p + c, p*63 + c = p*64 - p + c
    avg32_sum = {1'b0, step_period, 5'd0} - {6'd0, step_period}
              + {6'd0, ev.timer_count};
    avg64_sum = {1'b0, step_period, 6'd0} - {7'd0, step_period}
              + {7'd0, ev.timer_count};
    avg32    = avg32_sum[DATA_W+4:5];
    avg64    = avg64_sum[DATA_W+5:6];
    good_inc = (good_count == COUNT_MAX) ? COUNT_MAX : good_count + 16'd1;
    fail_inc = (fail_count == COUNT_MAX) ? COUNT_MAX : fail_count + 16'd1;
  end

  always_comb begin
    step_period_next   = step_period;
    good_count_next    = good_count;
    fail_count_next    = fail_count;
    res.commutate      = 1'b0;
    res.zero_cross_off = 1'b0;
    res.reload_valid   = 1'b0;
    res.reload_value   = '0;
    case (event_kind_t'(ev.kind))
      KIND_ZERO_CROSS: begin
        if (running && !early) begin
          fail_count_next    = '0;
          good_count_next    = good_inc;
          step_period_next   = avg32;
          res.zero_cross_off = 1'b1;
          res.reload_valid   = 1'b1;
          res.reload_value   = (run_mode_t'(ev.run_mode) == MODE_DRAG) ?
                               cfg.drag_step_reload : {1'b0, avg32[DATA_W-1:1]};
        end
      end
      KIND_TIMEOUT: begin
        if (running) begin
          if (run_mode_t'(ev.run_mode) == MODE_DRAG) begin
            good_count_next = '0;
          end
          fail_count_next  = fail_inc;
          step_period_next = avg64;
          res.commutate    = 1'b1;
          res.reload_valid = 1'b1;
          res.reload_value = cfg.step_timeout_reload;
        end
      end
      KIND_COMMUTATE: begin
        if (running) begin
          res.commutate    = 1'b1;
          res.reload_valid = 1'b1;
          res.reload_value = cfg.step_timeout_reload;
        end
      end
      default: ;
    endcase
    res.step_estimate = step_period_next;
    res.good_steps    = good_count_next;
    res.failed_steps  = fail_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_period <= START_PERIOD_RESET;
      good_count  <= '0;
      fail_count  <= '0;
    end else if (update) begin
      step_period <= step_period_next;
      good_count  <= good_count_next;
      fail_count  <= fail_count_next;
    end
  end

endmodule

// File: rtl/bldc_commutation_timing_top.sv
// ----------------------------------------------------------------------------
// bldc_commutation_timing_top
// Sensorless BLDC commutation timing: period filter, step counters, strobes.
// ----------------------------------------------------------------------------
// Usage:
//   Events enter on the s_ stream: s_tuser carries the event kind, s_tdata
//   the run mode and the captured step timer count. Each accepted request
//   gives exactly one result on the m_ stream (strobes, timer reload, the
//   filtered step period and the good/failed step counts after the event).
//   An accepted request waits in the input register; its result enters the
//   output register when that advances and is shown from then on. One request
//   is taken per cycle while the output advances; each period and counter
//   update feeds the next request. m_tready low holds the output register;
//   the input register still takes one more request, then s_tready drops
//   until the output drains. Configuration (cfg_we, cfg_index, cfg_data) is
//   to be written while idle; the block does not enforce it. Reset (rst,
//   synchronous) empties both registers, restores the register reset values
//   and loads the step period with the start period reset value.
// ----------------------------------------------------------------------------
module bldc_commutation_timing_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // [1:0] run_mode, [17:2] timer_count, rest zero
  input  logic [bct_pkg::IN_TDATA_W-1:0]       s_tdata,
  // [1:0] kind
  input  logic [bct_pkg::IN_TUSER_W-1:0]       s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [0] commutate, [1] zero_cross_off, [2] reload_valid, [18:3] reload_value,
  // [34:19] step_estimate, [50:35] good_steps, [66:51] failed_steps, rest zero
  output logic [bct_pkg::OUT_TDATA_W-1:0]      m_tdata,
  input  logic                                 cfg_we,
  input  logic [bct_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [bct_pkg::DATA_W-1:0]           cfg_data
);
  import bct_pkg::*;

  cfg_t    cfg;
  event_t  ev;
  logic    ev_valid;
  result_t res;
  result_t res_reg;
  logic    advance;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !ev_valid || advance;

  bct_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bct_step_unit u_step (
    .clk    (clk),
    .rst    (rst),
    .update (ev_valid && advance),
    .ev     (ev),
    .cfg    (cfg),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (s_tready) begin
      ev_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      ev.kind        <= s_tuser[1:0];
      ev.run_mode    <= s_tdata[1:0];
      ev.timer_count <= s_tdata[17:2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= ev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_valid && advance) begin
      res_reg <= res;
    end
  end

  assign m_tdata = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, res_reg};

endmodule

// File: bench/bldc_commutation_timing_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bldc_commutation_timing_top_test
// Self-checking bench for the sensorless BLDC commutation timing block.
// A table of directed events runs first. Randomised event streams follow
// under three idle patterns and several register settings. Every result is
// compared field by field with its table row's fixed value or a behavioural
// predictor of the period filter, the step counters and the reload selection.
// ----------------------------------------------------------------------------
module bldc_commutation_timing_top_test;
  import bct_pkg::*;

  localparam logic [1:0] KIND_UNKNOWN = 2'd3;
  localparam logic [1:0] MODE_UNKNOWN = 2'd3;
  localparam int unsigned MAX_REPORTS = 40;

  // state straight after reset, nothing strobed
  localparam result_t IDLE_RESULT =
    '{16'd0, 16'd0, 16'd4000, 16'd0, 1'b0, 1'b0, 1'b0};
  localparam result_t COMMUTATE_RESULT =
    '{16'd0, 16'd0, 16'd4000, 16'd65535, 1'b1, 1'b0, 1'b1};

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  mode;
    logic [15:0] count;
    logic        fixed;
    result_t     want;
  } directed_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]      cfg_data = '0;

  // predictor state and register copies
  logic [15:0] period_est = START_PERIOD_RESET;
  logic [15:0] good_run = '0;
  logic [15:0] fail_run = '0;
  logic [15:0] timeout_reload = STEP_TIMEOUT_RESET;
  logic [15:0] drag_reload = DRAG_STEP_RESET;

  result_t expected_results [$];
  int error_count = 0;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int hold_request = 0;

  directed_row_t directed_rows [21] = '{
    '{KIND_COMMUTATE,  MODE_IDLE,    16'd0,     1'b1, IDLE_RESULT},
    '{KIND_UNKNOWN,    MODE_CLOSED,  16'd65535, 1'b1, IDLE_RESULT},
    '{KIND_COMMUTATE,  MODE_UNKNOWN, 16'd65535, 1'b1, IDLE_RESULT},
    '{KIND_ZERO_CROSS, MODE_CLOSED,  16'd999,   1'b1, IDLE_RESULT},
    '{KIND_TIMEOUT,    MODE_IDLE,    16'd65535, 1'b1, IDLE_RESULT},
    '{KIND_ZERO_CROSS, MODE_IDLE,    16'd65535, 1'b1, IDLE_RESULT},
    '{KIND_COMMUTATE,  MODE_DRAG,    16'd0,     1'b1, COMMUTATE_RESULT},
    '{KIND_COMMUTATE,  MODE_CLOSED,  16'd65535, 1'b1, COMMUTATE_RESULT},
    '{KIND_ZERO_CROSS, MODE_CLOSED,  16'd1000,  1'b0, '0},
    '{KIND_ZERO_CROSS, MODE_DRAG,    16'd65535, 1'b0, '0},
    '{KIND_TIMEOUT,    MODE_DRAG,    16'd0,     1'b0, '0},
    '{KIND_TIMEOUT,    MODE_CLOSED,  16'd65535, 1'b0, '0},
    '{KIND_TIMEOUT,    MODE_UNKNOWN, 16'd0,     1'b0, '0},
    '{KIND_ZERO_CROSS, MODE_UNKNOWN, 16'd65535, 1'b0, '0},
    '{KIND_ZERO_CROSS, MODE_CLOSED,  16'hAAAA,  1'b0, '0},
    '{KIND_ZERO_CROSS, MODE_DRAG,    16'h5555,  1'b0, '0},
    '{KIND_ZERO_CROSS, MODE_CLOSED,  16'd0,     1'b0, '0},
    '{KIND_UNKNOWN,    MODE_DRAG,    16'h5555,  1'b0, '0},
    '{KIND_TIMEOUT,    MODE_CLOSED,  16'hAAAA,  1'b0, '0},
    '{KIND_COMMUTATE,  MODE_DRAG,    16'hFFFF,  1'b0, '0},
    '{KIND_ZERO_CROSS, MODE_DRAG,    16'd1,     1'b0, '0}
  };

  bldc_commutation_timing_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] count_up(logic [15:0] v);
    return (v == COUNT_MAX) ? v : v + 16'd1;
  endfunction

  function automatic result_t predict_commutation(logic [1:0] kind, logic [1:0] mode,
                                                  logic [15:0] count);
    result_t r;
    logic running;
    logic [31:0] acc;
    r = '0;
    running = (mode == MODE_DRAG) || (mode == MODE_CLOSED);
    if (running) begin
      case (kind)
        KIND_ZERO_CROSS: begin
          // early crossings are noise
          if ({16'd0, count} >= {16'd0, period_est} / MIN_ADVANCE_DIVISOR) begin
            fail_run = '0;
            good_run = count_up(good_run);
            acc = ({16'd0, period_est} * 32'd31 + {16'd0, count}) / 32'd32;
            period_est = acc[15:0];
            r.zero_cross_off = 1'b1;
            r.reload_valid = 1'b1;
            r.reload_value = (mode == MODE_DRAG) ? drag_reload : (period_est >> 1);
          end
        end
        KIND_TIMEOUT: begin
          if (mode == MODE_DRAG) begin
            good_run = '0;
          end
          fail_run = count_up(fail_run);
          acc = ({16'd0, period_est} * 32'd63 + {16'd0, count}) / 32'd64;
          period_est = acc[15:0];
          r.commutate = 1'b1;
          r.reload_valid = 1'b1;
          r.reload_value = timeout_reload;
        end
        KIND_COMMUTATE: begin
          r.commutate = 1'b1;
          r.reload_valid = 1'b1;
          r.reload_value = timeout_reload;
        end
        default: begin
        end
      endcase
    end
    r.step_estimate = period_est;
    r.good_steps = good_run;
    r.failed_steps = fail_run;
    return r;
  endfunction

  task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      if (error_count < MAX_REPORTS) begin
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
      error_count++;
    end
  endtask

  task automatic check_result(logic [OUT_TDATA_W-1:0] word);
    result_t got;
    result_t want;
    got = word[$bits(result_t)-1:0];
    if (expected_results.size() == 0) begin
      $display("%0t: result with no request outstanding, actual %h", $time, word);
      error_count++;
    end else begin
      want = expected_results.pop_front();
      compare_field("commutate", 16'(want.commutate), 16'(got.commutate));
      compare_field("zero_cross_off", 16'(want.zero_cross_off), 16'(got.zero_cross_off));
      compare_field("reload_valid", 16'(want.reload_valid), 16'(got.reload_valid));
      compare_field("reload_value", want.reload_value, got.reload_value);
      compare_field("step_estimate", want.step_estimate, got.step_estimate);
      compare_field("good_steps", want.good_steps, got.good_steps);
      compare_field("failed_steps", want.failed_steps, got.failed_steps);
      compare_field("tdata padding", 16'd0,
                    16'(word[OUT_TDATA_W-1:$bits(result_t)]));
    end
  endtask

  task automatic send_event(logic [1:0] kind, logic [1:0] mode, logic [15:0] count,
                            logic fixed, result_t want);
    result_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {{(IN_TDATA_W-18){1'b0}}, count, mode};
    do @(posedge clk); while (!s_tready);
    predicted = predict_commutation(kind, mode, count);
    expected_results.push_back(fixed ? want : predicted);
  endtask

  task automatic random_event(output logic [1:0] kind, output logic [1:0] mode,
                              output logic [15:0] count);
    int pick;
    int around;
    pick = $urandom_range(99);
    if (pick < 45) kind = KIND_ZERO_CROSS;
    else if (pick < 70) kind = KIND_TIMEOUT;
    else if (pick < 90) kind = KIND_COMMUTATE;
    else kind = KIND_UNKNOWN;
    pick = $urandom_range(99);
    if (pick < 45) mode = MODE_CLOSED;
    else if (pick < 80) mode = MODE_DRAG;
    else if (pick < 90) mode = MODE_IDLE;
    else mode = MODE_UNKNOWN;
    // counts near the period, near the noise threshold, anywhere, or at the ends
    pick = $urandom_range(99);
    if (pick < 45) around = int'(period_est) + int'($urandom_range(2000)) - 1000;
    else if (pick < 65)
      around = int'({16'd0, period_est} / MIN_ADVANCE_DIVISOR) + int'($urandom_range(4)) - 2;
    else if (pick < 88) around = int'($urandom_range(65535));
    else around = ($urandom_range(1) != 0) ? 65535 : 0;
    if (around < 0) count = 16'd0;
    else if (around > 65535) count = 16'hFFFF;
    else count = around[15:0];
  endtask

  task automatic run_random(int n);
    logic [1:0] kind;
    logic [1:0] mode;
    logic [15:0] count;
    repeat (n) begin
      random_event(kind, mode, count);
      send_event(kind, mode, count, 1'b0, '0);
    end
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_STEP_TIMEOUT_RELOAD: timeout_reload = value;
      REG_DRAG_STEP_RELOAD:    drag_reload = value;
      // start period only matters at reset
      default: begin
      end
    endcase
  endtask

  task automatic apply_settings(logic [15:0] timeout_val, logic [15:0] drag_val,
                                logic [15:0] start_val);
    wait_for_results();
    write_reg(REG_STEP_TIMEOUT_RELOAD, timeout_val);
    write_reg(REG_DRAG_STEP_RELOAD, drag_val);
    write_reg(REG_START_STEP_PERIOD, start_val);
    cfg_we <= 1'b0;
  endtask

  initial begin : result_monitor
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        check_result(m_tdata);
      end
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    src_idle_pct = 24;
    sink_idle_pct = 60;
    foreach (directed_rows[i]) begin
      send_event(directed_rows[i].kind, directed_rows[i].mode, directed_rows[i].count,
                 directed_rows[i].fixed, directed_rows[i].want);
    end

    apply_settings(16'd1, 16'd65535, 16'd0);
    run_random(150);
    // receiver stalls while requests keep coming
    hold_request = 400;
    run_random(150);
    wait_for_results();
    run_random(200);

    src_idle_pct = 60;
    sink_idle_pct = 24;
    apply_settings(16'd65535, 16'd1, 16'd65535);
    run_random(500);

    src_idle_pct = 0;
    sink_idle_pct = 0;
    apply_settings(16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1)),
                   16'($urandom_range(65535)));
    run_random(500);
    wait_for_results();

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : run_limit
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// File: filelist.f
rtl/bct_pkg.sv
rtl/bct_cfg_regs.sv
rtl/bct_step_unit.sv
rtl/bldc_commutation_timing_top.sv
bench/bldc_commutation_timing_top_test.sv
